// File: hw/rtl/abi_argument_placer_assert.svh
// Assertion macros for the argument placer.
// Users provide clk_i and rst_ni in scope; no other dependencies.
`ifndef ABI_ARGUMENT_PLACER_ASSERT_SVH
`define ABI_ARGUMENT_PLACER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define ABAP_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ABAP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/abap_pkg.sv
// Shared types and codes for the argument placer.
// No dependencies.
`timescale 1ns / 1ps

package abap_pkg;

  localparam logic [1:0] CMD_BEGIN  = 2'd0;
  localparam logic [1:0] CMD_PARAM  = 2'd1;
  localparam logic [1:0] CMD_RETURN = 2'd2;

  localparam logic [1:0] KIND_INT     = 2'd0;
  localparam logic [1:0] KIND_FLOAT   = 2'd1;
  localparam logic [1:0] KIND_MEM     = 2'd2;
  localparam logic [1:0] KIND_MEM_ALT = 2'd3;

  localparam logic [1:0] WHERE_INT      = 2'd0;
  localparam logic [1:0] WHERE_FLOAT    = 2'd1;
  localparam logic [1:0] WHERE_STACK    = 2'd2;
  localparam logic [1:0] WHERE_INDIRECT = 2'd3;

  // eightbyte class flag bits
  localparam int unsigned FL_F1 = 0;
  localparam int unsigned FL_F2 = 1;
  localparam int unsigned FL_I1 = 2;
  localparam int unsigned FL_I2 = 3;

  localparam int unsigned EIGHTBYTE      = 8;
  localparam int unsigned TWO_EIGHTBYTES = 16;

  typedef struct packed {
    logic [1:0] command;
    logic [1:0] member_kind;
    logic [7:0] member_size;
    logic [2:0] member_align_log2;
    logic       last_member;
  } req_t;

  typedef struct packed {
    logic [1:0]  first_where;
    logic [2:0]  first_index;
    logic        is_pair;
    logic        second_where;
    logic [2:0]  second_index;
    logic [15:0] stack_offset;
    logic        error;
  } rsp_t;

endpackage

// File: hw/rtl/abap_if.sv
// Request and result channel interfaces for the argument placer.
// Standalone; valid/ready handshake with flat payload fields.
`timescale 1ns / 1ps

interface abap_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [1:0] member_kind;
  logic [7:0] member_size;
  logic [2:0] member_align_log2;
  logic       last_member;

  modport source (output valid, command, member_kind, member_size, member_align_log2,
                  last_member, input ready);
  modport sink (input valid, command, member_kind, member_size, member_align_log2,
                last_member, output ready);
endinterface

interface abap_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  first_where;
  logic [2:0]  first_index;
  logic        is_pair;
  logic        second_where;
  logic [2:0]  second_index;
  logic [15:0] stack_offset;
  logic        error;

  modport source (output valid, first_where, first_index, is_pair, second_where,
                  second_index, stack_offset, error, input ready);
  modport sink (input valid, first_where, first_index, is_pair, second_where,
                second_index, stack_offset, error, output ready);
endinterface

// File: hw/rtl/abi_argument_placer.sv
// Top level of the SysV-style argument placer: input register, placement core, result register.
// Depends on abap_pkg, abap_if, abap_in_stage, abap_place_core, abap_out_stage.
//
//   channel  | dir | payload
//   ---------+-----+-----------------------------------------------------------
//   req_i    | in  | command, member_kind, member_size, member_align_log2, last
//   rsp_o    | out | first/second where+index, is_pair, stack_offset, error
//
// One request per cycle unless a held result stalls the input register; a result passes
// through the input register, the placement core and the result register before rsp_o.
// Latency is set by the input register and the result register around the core.
// Reset clears pools, stack top and the aggregate in progress.
// A held result stalls only requests that produce one; others keep flowing.
`timescale 1ns / 1ps

module abi_argument_placer #(
  parameter int unsigned INT_ARG_REGS        = 6,
  parameter int unsigned FLOAT_ARG_REGS      = 8,
  parameter int unsigned MAX_AGGREGATE_BYTES = 4096,
  parameter int unsigned STACK_OFFSET_BITS   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  abap_req_if.sink    req_i,
  abap_rsp_if.source  rsp_o
);
  import abap_pkg::*;

  logic s1_valid;
  req_t s1_req;
  logic core_rsp_valid;
  rsp_t core_rsp;
  logic out_room;
  logic fire;

  assign fire = s1_valid && (!core_rsp_valid || out_room);

  abap_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_i),
    .take_i  (fire),
    .valid_o (s1_valid),
    .req_o   (s1_req)
  );

  abap_place_core #(
    .INT_ARG_REGS        (INT_ARG_REGS),
    .FLOAT_ARG_REGS      (FLOAT_ARG_REGS),
    .MAX_AGGREGATE_BYTES (MAX_AGGREGATE_BYTES),
    .STACK_OFFSET_BITS   (STACK_OFFSET_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .req_i       (s1_req),
    .rsp_valid_o (core_rsp_valid),
    .rsp_o       (core_rsp)
  );

  abap_out_stage u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (fire && core_rsp_valid),
    .rsp_i  (core_rsp),
    .room_o (out_room),
    .rsp_o  (rsp_o)
  );

endmodule

// File: hw/rtl/abap_in_stage.sv
// Input register stage: captures one request per cycle from the request channel while the held one is taken.
// Depends on abap_pkg and abap_req_if.
`timescale 1ns / 1ps

module abap_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  abap_req_if.sink        req_i,
  input  logic            take_i,
  output logic            valid_o,
  output abap_pkg::req_t  req_o
);
  import abap_pkg::*;

  logic valid_q;
  logic valid_d;
  req_t req_q;
  logic accept;

  assign req_i.ready = !valid_q || take_i;
  assign accept      = req_i.valid && req_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q.command           <= req_i.command;
      req_q.member_kind       <= req_i.member_kind;
      req_q.member_size       <= req_i.member_size;
      req_q.member_align_log2 <= req_i.member_align_log2;
      req_q.last_member       <= req_i.last_member;
    end
  end

  assign valid_o = valid_q;
  assign req_o   = req_q;

endmodule

// File: hw/rtl/abap_place_core.sv
// Placement state and combinational placement logic for one member request.
// Depends on abap_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "abi_argument_placer_assert.svh"

module abap_place_core #(
  parameter int unsigned INT_ARG_REGS        = 6,
  parameter int unsigned FLOAT_ARG_REGS      = 8,
  parameter int unsigned MAX_AGGREGATE_BYTES = 4096,
  parameter int unsigned STACK_OFFSET_BITS   = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           fire_i,
  input  abap_pkg::req_t req_i,
  output logic           rsp_valid_o,
  output abap_pkg::rsp_t rsp_o
);
  import abap_pkg::*;

  localparam int unsigned IW  = $clog2(INT_ARG_REGS + 1);
  localparam int unsigned FW  = $clog2(FLOAT_ARG_REGS + 1);
  localparam int unsigned AGW = $clog2(MAX_AGGREGATE_BYTES + 2);
  localparam int unsigned SW  = STACK_OFFSET_BITS + 1;
  localparam int unsigned CW0 = (SW > AGW) ? SW : AGW;
  localparam int unsigned CW  = ((CW0 > 16) ? CW0 : 16) + 2;

  logic [IW-1:0]  int_q,   int_d;
  logic [FW-1:0]  fp_q,    fp_d;
  logic [SW-1:0]  stack_q, stack_d;
  logic [AGW-1:0] aggb_q,  aggb_d;
  logic [2:0]     agal_q,  agal_d;
  logic [3:0]     flags_q, flags_d;
  logic           inside_q, inside_d;

  logic           is_mem, is_fp, single;
  logic [6:0]     m_mask, st_mask;
  logic [CW-1:0]  t_sum, st_size, st_start, st_end;
  logic [AGW-1:0] aggb_new;
  logic [2:0]     agal_new, st_alog;
  logic [3:0]     flags_new;
  logic           f1, f2, st_ovf;
  logic           int_ok, fp_ok;
  logic           a1f, a1i, a2f, a2i;
  logic [IW-1:0]  ni1, ni2;
  logic [FW-1:0]  nf1, nf2;
  logic [2:0]     i1, i2;
  logic           use_stk;
  rsp_t           rsp;

  assign is_mem = (req_i.member_kind == KIND_MEM) || (req_i.member_kind == KIND_MEM_ALT);
  assign is_fp  = (req_i.member_kind == KIND_FLOAT);
  assign single = req_i.last_member && !inside_q && ((req_i.command == CMD_RETURN) || !is_mem);

  // running aggregate layout
  assign m_mask = 7'((8'd1 << req_i.member_align_log2) - 8'd1);
  assign t_sum  = ((CW'(aggb_q) + CW'(m_mask)) & ~CW'(m_mask)) + CW'(req_i.member_size);
  assign aggb_new = (t_sum > CW'(MAX_AGGREGATE_BYTES)) ? AGW'(MAX_AGGREGATE_BYTES + 1)
                                                      : t_sum[AGW-1:0];
  assign agal_new = (req_i.member_align_log2 > agal_q) ? req_i.member_align_log2 : agal_q;

  always_comb begin
    flags_new = flags_q;
    if (t_sum <= CW'(EIGHTBYTE)) begin
      if (is_fp) begin
        flags_new[FL_F1] = 1'b1;
      end else begin
        flags_new[FL_I1] = 1'b1;
      end
    end else if (t_sum <= CW'(TWO_EIGHTBYTES)) begin
      if (is_fp) begin
        flags_new[FL_F2] = 1'b1;
      end else begin
        flags_new[FL_I2] = 1'b1;
      end
    end
  end

  assign f1 = flags_new[FL_F1] && !flags_new[FL_I1];
  assign f2 = flags_new[FL_F2] && !flags_new[FL_I2];

  // stack slot
  assign st_size  = single ? CW'(req_i.member_size) : CW'(aggb_new);
  assign st_alog  = single ? req_i.member_align_log2 : agal_new;
  assign st_mask  = 7'((8'd1 << st_alog) - 8'd1);
  assign st_start = (CW'(stack_q) + CW'(st_mask)) & ~CW'(st_mask);
  assign st_end   = st_start + st_size;
  assign st_ovf   = st_end > (CW'(1) << STACK_OFFSET_BITS);

  // register pools for a small aggregate
  assign int_ok = int_q < IW'(INT_ARG_REGS);
  assign fp_ok  = fp_q < FW'(FLOAT_ARG_REGS);
  assign a1f    = f1 && fp_ok;
  assign a1i    = !a1f && int_ok;
  assign ni1    = int_q + IW'(a1i);
  assign nf1    = fp_q + FW'(a1f);
  assign i1     = a1f ? 3'(fp_q) : 3'(int_q);
  assign a2f    = f2 && (nf1 < FW'(FLOAT_ARG_REGS));
  assign a2i    = !a2f && (ni1 < IW'(INT_ARG_REGS));
  assign ni2    = ni1 + IW'(a2i);
  assign nf2    = nf1 + FW'(a2f);
  assign i2     = a2f ? 3'(nf1) : 3'(ni1);

  always_comb begin
    rsp      = '0;
    use_stk  = 1'b0;
    int_d    = int_q;
    fp_d     = fp_q;
    stack_d  = stack_q;
    aggb_d   = aggb_q;
    agal_d   = agal_q;
    flags_d  = flags_q;
    inside_d = inside_q;
    unique case (req_i.command) inside
      CMD_BEGIN: begin
        int_d    = '0;
        fp_d     = '0;
        stack_d  = '0;
        aggb_d   = '0;
        agal_d   = '0;
        flags_d  = '0;
        inside_d = 1'b0;
      end
      CMD_PARAM, CMD_RETURN: begin
        aggb_d   = aggb_new;
        agal_d   = agal_new;
        flags_d  = flags_new;
        inside_d = 1'b1;
        if (req_i.last_member) begin
          aggb_d   = '0;
          agal_d   = '0;
          flags_d  = '0;
          inside_d = 1'b0;
          if (req_i.command == CMD_PARAM) begin
            if (single && !is_fp) begin
              if (int_ok) begin
                rsp.first_where = WHERE_INT;
                rsp.first_index = 3'(int_q);
                int_d           = int_q + IW'(1);
              end else begin
                use_stk = 1'b1;
              end
            end else if (single) begin
              if (fp_ok) begin
                rsp.first_where = WHERE_FLOAT;
                rsp.first_index = 3'(fp_q);
                fp_d            = fp_q + FW'(1);
              end else begin
                use_stk = 1'b1;
              end
            end else if (aggb_new > AGW'(MAX_AGGREGATE_BYTES)) begin
              rsp.first_where = WHERE_STACK;
              rsp.error       = 1'b1;
            end else if (aggb_new > AGW'(TWO_EIGHTBYTES)) begin
              use_stk = 1'b1;
            end else if (!(a1f || a1i)) begin
              use_stk = 1'b1;
            end else if (aggb_new <= AGW'(EIGHTBYTE)) begin
              rsp.first_where = a1f ? WHERE_FLOAT : WHERE_INT;
              rsp.first_index = i1;
              int_d           = ni1;
              fp_d            = nf1;
            end else if (!(a2f || a2i)) begin
              use_stk = 1'b1;
            end else begin
              rsp.first_where  = a1f ? WHERE_FLOAT : WHERE_INT;
              rsp.first_index  = i1;
              rsp.is_pair      = 1'b1;
              rsp.second_where = a2f;
              rsp.second_index = i2;
              int_d            = ni2;
              fp_d             = nf2;
            end
          end else begin
            if (single) begin
              rsp.first_where = is_fp ? WHERE_FLOAT : WHERE_INT;
              rsp.error       = is_mem;
            end else if (aggb_new <= AGW'(EIGHTBYTE)) begin
              rsp.first_where = f1 ? WHERE_FLOAT : WHERE_INT;
            end else if (aggb_new <= AGW'(TWO_EIGHTBYTES)) begin
              rsp.first_where  = f1 ? WHERE_FLOAT : WHERE_INT;
              rsp.is_pair      = 1'b1;
              rsp.second_where = f2;
              rsp.second_index = (f2 == f1) ? 3'd1 : 3'd0;
            end else if (int_ok) begin
              rsp.first_where = WHERE_INDIRECT;
              rsp.first_index = 3'(int_q);
              int_d           = int_q + IW'(1);
            end else begin
              rsp.first_where = WHERE_INDIRECT;
              rsp.error       = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    if (use_stk) begin
      rsp.first_where  = WHERE_STACK;
      rsp.error        = st_ovf;
      rsp.stack_offset = st_ovf ? 16'd0 : st_start[15:0];
      if (!st_ovf) begin
        stack_d = st_end[SW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      int_q    <= '0;
      fp_q     <= '0;
      stack_q  <= '0;
      aggb_q   <= '0;
      agal_q   <= '0;
      flags_q  <= '0;
      inside_q <= 1'b0;
    end else if (fire_i) begin
      int_q    <= int_d;
      fp_q     <= fp_d;
      stack_q  <= stack_d;
      aggb_q   <= aggb_d;
      agal_q   <= agal_d;
      flags_q  <= flags_d;
      inside_q <= inside_d;
    end
  end

  assign rsp_valid_o = req_i.last_member &&
                       ((req_i.command == CMD_PARAM) || (req_i.command == CMD_RETURN));
  assign rsp_o = rsp;

  `ABAP_ASSERT(a_int_pool_bound, 1'b1, int_q <= IW'(INT_ARG_REGS), "int pool overrun")
  `ABAP_ASSERT(a_fp_pool_bound, 1'b1, fp_q <= FW'(FLOAT_ARG_REGS), "float pool overrun")
  `ABAP_ASSERT_NEXT(a_begin_clears, fire_i && (req_i.command == CMD_BEGIN),
    (int_q == '0) && (fp_q == '0) && (stack_q == '0) && !inside_q, "begin did not clear")
  `ABAP_ASSERT(a_pair_in_regs, rsp_valid_o && rsp_o.is_pair,
    (rsp_o.first_where == WHERE_INT) || (rsp_o.first_where == WHERE_FLOAT), "pair not in regs")
  `ABAP_ASSERT(a_stack_err_zero, rsp_valid_o && rsp_o.error && (rsp_o.first_where == WHERE_STACK),
    rsp_o.stack_offset == 16'd0, "stack error with offset")

endmodule

// File: hw/rtl/abap_out_stage.sv
// Result register stage driving the result channel.
// Depends on abap_pkg and abap_rsp_if.
`timescale 1ns / 1ps

module abap_out_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  abap_pkg::rsp_t  rsp_i,
  output logic            room_o,
  abap_rsp_if.source      rsp_o
);
  import abap_pkg::*;

  logic valid_q;
  logic valid_d;
  rsp_t rsp_q;

  assign room_o = !valid_q || rsp_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rsp_q <= rsp_i;
    end
  end

  assign rsp_o.valid        = valid_q;
  assign rsp_o.first_where  = rsp_q.first_where;
  assign rsp_o.first_index  = rsp_q.first_index;
  assign rsp_o.is_pair      = rsp_q.is_pair;
  assign rsp_o.second_where = rsp_q.second_where;
  assign rsp_o.second_index = rsp_q.second_index;
  assign rsp_o.stack_offset = rsp_q.stack_offset;
  assign rsp_o.error        = rsp_q.error;

endmodule
